// ----- rtl/pinned_lru_identity_table_assert.svh -----
// ----------------------------------------------------------------------------
// pinned lru identity table assertion macros
// concurrent checks clocked by i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef PINNED_LRU_IDENTITY_TABLE_ASSERT_SVH
`define PINNED_LRU_IDENTITY_TABLE_ASSERT_SVH

// same-cycle implication
`define PLT_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pinned table check failed");

// next-cycle implication
`define PLT_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pinned table check failed");

`endif

// ----- rtl/plt_pkg.sv -----
// ----------------------------------------------------------------------------
// plt_pkg
// shared sizes, codes and types of the pinned lru identity table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plt_pkg;

    localparam int ENTRIES  = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int TIME_W   = 48;
    localparam int HITS_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_HIT         = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_WATCHED = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_MUTED   = 3'd2;
    localparam logic [OP_W-1:0] OP_RESTORE     = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND        = 3'd4;
    localparam logic [OP_W-1:0] OP_READ        = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_REPLACED  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STS_DUPLICATE = 3'd5;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd6;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] first_seen;
        logic [TIME_W-1:0] last_seen;
        logic [HITS_W-1:0] hits;
        logic              watched;
        logic              muted;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] time_ms;
        logic [TIME_W-1:0] first_seen;
        logic [HITS_W-1:0] hits;
        logic              watched;
        logic              muted;
        logic [SLOT_W-1:0] index;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        t_entry              entry;
        logic [COUNT_W-1:0]  count;
    } t_result;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

endpackage

// ----- rtl/pinned_lru_identity_table.sv -----
// ----------------------------------------------------------------------------
// pinned_lru_identity_table: keyed pager table, lru replacement with pinning
// key operations scan the used entries of the store (one entry of the
//   store compared per cycle), then update and write back
// other operations skip the scan; one item at a time, the next is accepted
//   once the result has left the sequencer for the output register
// reset: synchronous active low, empties the table at once (no clearing pass)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pinned_lru_identity_table
    import plt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    // item channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [KEY_W-1:0]    i_capcode,
    input  logic [TIME_W-1:0]   i_time_ms,
    input  logic [TIME_W-1:0]   i_first_seen_ms,
    input  logic [HITS_W-1:0]   i_hit_count_in,
    input  logic                i_watched_in,
    input  logic                i_muted_in,
    input  logic [SLOT_W-1:0]   i_entry_index,

    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [KEY_W-1:0]    o_out_capcode,
    output logic [TIME_W-1:0]   o_out_first_seen_ms,
    output logic [TIME_W-1:0]   o_out_last_seen_ms,
    output logic [HITS_W-1:0]   o_out_hit_count,
    output logic                o_out_watched,
    output logic                o_out_muted,
    output logic [COUNT_W-1:0]  o_entry_count
);

    t_item    item;
    t_mem_req mem_req;
    t_entry   rd_data;
    t_result  res;
    logic     res_valid;
    logic     res_ready;

    logic     r_out_valid;
    t_result  r_out;

    // gather the item fields for the sequencer
    always_comb begin
        item.op         = i_opcode;
        item.key        = i_capcode;
        item.time_ms    = i_time_ms;
        item.first_seen = i_first_seen_ms;
        item.hits       = i_hit_count_in;
        item.watched    = i_watched_in;
        item.muted      = i_muted_in;
        item.index      = i_entry_index;
    end

    // entry store: key, times, hit count and flags side by side in one word
    plt_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // scan, update and write back; entries past the fill count are never read,
    // so clear only zeroes the count
    plt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (item),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register: the sequencer moves on once its result is parked here
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out.status;
    assign o_slot              = r_out.slot;
    assign o_out_capcode       = r_out.entry.key;
    assign o_out_first_seen_ms = r_out.entry.first_seen;
    assign o_out_last_seen_ms  = r_out.entry.last_seen;
    assign o_out_hit_count     = r_out.entry.hits;
    assign o_out_watched       = r_out.entry.watched;
    assign o_out_muted         = r_out.entry.muted;
    assign o_entry_count       = r_out.count;

endmodule

// ----- rtl/plt_mem.sv -----
// ----------------------------------------------------------------------------
// plt_mem
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plt_mem
    import plt_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/plt_ctrl.sv -----
// ----------------------------------------------------------------------------
// plt_ctrl
// sequencer: key scan over the entry store, update, write back and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pinned_lru_identity_table_assert.svh"

module plt_ctrl
    import plt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_item    i_item,
    output t_mem_req o_mem,
    input  t_entry   i_rd_data,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_result  o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        r_state,   n_state;
    logic [CNT_W-1:0]  r_used,    n_used;
    logic [CNT_W-1:0]  r_rd_idx,  n_rd_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_found,   n_found;
    logic [IDX_W-1:0]  r_pos,     n_pos;
    logic              r_have,    n_have;
    logic [TIME_W-1:0] r_best,    n_best;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    t_item             r_item,    n_item;
    t_result           r_res,     n_res;

    logic              match;
    logic              report;
    logic              wr;
    logic [IDX_W-1:0]  addr;
    logic [STATUS_W-1:0] status;
    t_entry            ent;
    t_mem_req          mem;

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_found    = r_found;
        n_pos      = r_pos;
        n_have     = r_have;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_item     = r_item;
        n_res      = r_res;
        mem        = '0;
        ent        = i_rd_data;
        wr         = 1'b0;
        report     = 1'b0;
        addr       = r_pos;
        status     = STS_OK;
        match      = r_cmp_vld && (i_rd_data.key == r_item.key);

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item    = i_item;
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_have    = 1'b0;
                    n_found   = 1'b0;
                    n_res     = '0;
                    case (i_item.op)
                        OP_HIT, OP_SET_WATCHED, OP_SET_MUTED, OP_FIND: begin
                            n_state = ST_SCAN;
                        end
                        OP_RESTORE: begin
                            if (r_used == CNT_W'(ENTRIES)) begin
                                n_res.status = STS_FULL;
                                n_res.count  = COUNT_W'(r_used);
                                n_state      = ST_DONE;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (32'(i_item.index) < 32'(r_used)) begin
                                n_found = 1'b1;
                                n_pos   = IDX_W'(i_item.index);
                                n_state = ST_READ;
                            end else begin
                                n_res.status = STS_RANGE;
                                n_res.count  = COUNT_W'(r_used);
                                n_state      = ST_DONE;
                            end
                        end
                        OP_CLEAR: begin
                            n_used       = '0;
                            n_res.status = STS_OK;
                            n_state      = ST_DONE;
                        end
                        default: begin
                            n_res.status = STS_RANGE;
                            n_res.count  = COUNT_W'(r_used);
                            n_state      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = r_pos;
                n_state     = ST_APPLY;
            end
            ST_SCAN: begin
                if (match) begin
                    // read data stays put: no read issued on a match
                    n_found   = 1'b1;
                    n_pos     = r_cmp_idx;
                    n_cmp_vld = 1'b0;
                    n_state   = ST_APPLY;
                end else begin
                    if (r_cmp_vld && !i_rd_data.watched &&
                        (!r_have || (i_rd_data.last_seen < r_best))) begin
                        n_have     = 1'b1;
                        n_best     = i_rd_data.last_seen;
                        n_best_idx = r_cmp_idx;
                    end
                    if (r_rd_idx < r_used) begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = r_rd_idx[IDX_W-1:0];
                        n_cmp_vld   = 1'b1;
                        n_cmp_idx   = r_rd_idx[IDX_W-1:0];
                        n_rd_idx    = r_rd_idx + CNT_W'(1);
                    end else begin
                        n_cmp_vld = 1'b0;
                        if (!r_cmp_vld) begin
                            n_found = 1'b0;
                            n_state = ST_APPLY;
                        end
                    end
                end
            end
            ST_APPLY: begin
                if (r_found) begin
                    report = 1'b1;
                    case (r_item.op)
                        OP_HIT: begin
                            ent.last_seen = r_item.time_ms;
                            if (ent.hits != '1) begin
                                ent.hits = ent.hits + HITS_W'(1);
                            end
                            wr = 1'b1;
                        end
                        OP_SET_WATCHED: begin
                            ent.watched = r_item.watched;
                            wr          = 1'b1;
                        end
                        OP_SET_MUTED: begin
                            ent.muted = r_item.muted;
                            wr        = 1'b1;
                        end
                        OP_RESTORE: begin
                            status = STS_DUPLICATE;
                        end
                        default: begin
                            status = STS_OK;
                        end
                    endcase
                end else begin
                    ent.key        = r_item.key;
                    ent.first_seen = r_item.time_ms;
                    ent.last_seen  = r_item.time_ms;
                    ent.hits       = HITS_W'(1);
                    ent.watched    = 1'b0;
                    ent.muted      = 1'b0;
                    case (r_item.op)
                        OP_HIT: begin
                            if (r_used < CNT_W'(ENTRIES)) begin
                                addr   = IDX_W'(r_used);
                                n_used = r_used + CNT_W'(1);
                                wr     = 1'b1;
                                report = 1'b1;
                                status = STS_INSERTED;
                            end else if (r_have) begin
                                addr   = r_best_idx;
                                wr     = 1'b1;
                                report = 1'b1;
                                status = STS_REPLACED;
                            end else begin
                                status = STS_FULL;
                            end
                        end
                        OP_RESTORE: begin
                            ent.first_seen = r_item.first_seen;
                            ent.hits       = r_item.hits;
                            ent.watched    = r_item.watched;
                            ent.muted      = r_item.muted;
                            addr           = IDX_W'(r_used);
                            n_used         = r_used + CNT_W'(1);
                            wr             = 1'b1;
                            report         = 1'b1;
                            status         = STS_INSERTED;
                        end
                        default: begin
                            status = STS_NOT_FOUND;
                        end
                    endcase
                end
                mem.wr_en    = wr;
                mem.wr_addr  = addr;
                mem.wr_data  = ent;
                n_res        = '0;
                n_res.status = status;
                n_res.count  = COUNT_W'(n_used);
                if (report) begin
                    n_res.slot  = SLOT_W'(addr);
                    n_res.entry = ent;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_have     <= n_have;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_item     <= n_item;
        r_res      <= n_res;
    end

    assign o_mem       = mem;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    `PLT_CHECK(a_no_rw_overlap, o_mem.wr_en, !o_mem.rd_en)
    `PLT_CHECK(a_used_bound, 1'b1, r_used <= CNT_W'(ENTRIES))
    `PLT_CHECK(a_wr_in_fill, o_mem.wr_en, 32'(o_mem.wr_addr) <= 32'(r_used))
    `PLT_CHECK_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, r_state != ST_IDLE)

endmodule

// ----- tb/sv/tb_pinned_lru_identity_table.sv -----
// ----------------------------------------------------------------------------
// tb_pinned_lru_identity_table
// self-checking bench for the pinned lru identity table: a queue of planned
// items feeds a valid/ready driver, a monitor predicts each accepted item on a
// shadow copy of the table and compares every result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pinned_lru_identity_table;

    import plt_pkg::*;

    // opcode 7 has no meaning in the block and must come back as range error
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 150;
    localparam int RUN_LIMIT_NS = 25_000_000;
    localparam int RANDOM_ITEMS = 450;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                i_clk               = 1'b0;
    logic                i_rst_n             = 1'b0;
    logic                i_in_valid          = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_opcode            = '0;
    logic [KEY_W-1:0]    i_capcode           = '0;
    logic [TIME_W-1:0]   i_time_ms           = '0;
    logic [TIME_W-1:0]   i_first_seen_ms     = '0;
    logic [HITS_W-1:0]   i_hit_count_in      = '0;
    logic                i_watched_in        = 1'b0;
    logic                i_muted_in          = 1'b0;
    logic [SLOT_W-1:0]   i_entry_index       = '0;
    logic                o_out_valid;
    logic                i_out_ready         = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [KEY_W-1:0]    o_out_capcode;
    logic [TIME_W-1:0]   o_out_first_seen_ms;
    logic [TIME_W-1:0]   o_out_last_seen_ms;
    logic [HITS_W-1:0]   o_out_hit_count;
    logic                o_out_watched;
    logic                o_out_muted;
    logic [COUNT_W-1:0]  o_entry_count;

    pinned_lru_identity_table DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_capcode           (i_capcode),
        .i_time_ms           (i_time_ms),
        .i_first_seen_ms     (i_first_seen_ms),
        .i_hit_count_in      (i_hit_count_in),
        .i_watched_in        (i_watched_in),
        .i_muted_in          (i_muted_in),
        .i_entry_index       (i_entry_index),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_slot              (o_slot),
        .o_out_capcode       (o_out_capcode),
        .o_out_first_seen_ms (o_out_first_seen_ms),
        .o_out_last_seen_ms  (o_out_last_seen_ms),
        .o_out_hit_count     (o_out_hit_count),
        .o_out_watched       (o_out_watched),
        .o_out_muted         (o_out_muted),
        .o_entry_count       (o_entry_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_item            planned_items[$];   // items waiting for the driver
    t_result          awaited_results[$]; // predicted results, oldest first
    int               fail_count = 0;

    // shadow copy of the identity table
    t_entry           shadow_tab [ENTRIES];
    int unsigned      shadow_used;

    // generator bookkeeping
    logic [KEY_W-1:0] known_keys[$];      // keys hit or restored since last clear
    logic [TIME_W-1:0] gen_clock = '0;

    // driver and receiver pacing
    int               send_idle = 0;
    int               send_calm = 0;
    int               recv_stall = 0;
    int               recv_calm = 0;
    t_item            nxt;
    t_item            seen;
    t_result          want;

    // ------------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------------
    function automatic void shadow_clear();
        foreach (shadow_tab[i]) shadow_tab[i] = '0;
        shadow_used = 0;
    endfunction

    // slot holding the key among the used entries, -1 when absent
    function automatic int key_lookup(input logic [KEY_W-1:0] key);
        for (int i = 0; i < int'(shadow_used); i++)
            if (shadow_tab[i].key == key) return i;
        return -1;
    endfunction

    function automatic t_result table_apply(input t_item it);
        t_result            r;
        int                 k;
        int                 pos;
        logic               have;
        logic [TIME_W-1:0]  best;
        r        = '0;
        r.status = STS_RANGE;
        pos      = -1;
        case (it.op)
            OP_HIT: begin
                k = key_lookup(it.key);
                if (k >= 0) begin
                    shadow_tab[k].last_seen = it.time_ms;
                    // hit count saturates at all ones
                    if (shadow_tab[k].hits != '1)
                        shadow_tab[k].hits = shadow_tab[k].hits + 1'b1;
                    r.status = STS_OK;
                    pos      = k;
                end else begin
                    if (shadow_used < ENTRIES) begin
                        pos         = int'(shadow_used);
                        shadow_used = shadow_used + 1;
                        r.status    = STS_INSERTED;
                    end else begin
                        // oldest unwatched entry, strict compare keeps lowest index on ties
                        have = 1'b0;
                        best = '0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (!shadow_tab[i].watched &&
                                (!have || shadow_tab[i].last_seen < best)) begin
                                best = shadow_tab[i].last_seen;
                                pos  = i;
                                have = 1'b1;
                            end
                        end
                        r.status = have ? STS_REPLACED : STS_FULL;
                    end
                    if (pos >= 0) begin
                        shadow_tab[pos].key        = it.key;
                        shadow_tab[pos].first_seen = it.time_ms;
                        shadow_tab[pos].last_seen  = it.time_ms;
                        shadow_tab[pos].hits       = HITS_W'(1);
                        shadow_tab[pos].watched    = 1'b0;
                        shadow_tab[pos].muted      = 1'b0;
                    end
                end
            end
            OP_SET_WATCHED, OP_SET_MUTED: begin
                k = key_lookup(it.key);
                if (k >= 0) begin
                    if (it.op == OP_SET_WATCHED) shadow_tab[k].watched = it.watched;
                    else                         shadow_tab[k].muted   = it.muted;
                    r.status = STS_OK;
                    pos      = k;
                end else begin
                    r.status = STS_NOT_FOUND;
                end
            end
            OP_RESTORE: begin
                // fullness wins over duplicate detection
                if (shadow_used >= ENTRIES) begin
                    r.status = STS_FULL;
                end else begin
                    k = key_lookup(it.key);
                    if (k >= 0) begin
                        r.status = STS_DUPLICATE;
                        pos      = k;
                    end else begin
                        pos         = int'(shadow_used);
                        shadow_used = shadow_used + 1;
                        shadow_tab[pos].key        = it.key;
                        shadow_tab[pos].first_seen = it.first_seen;
                        shadow_tab[pos].last_seen  = it.time_ms;
                        shadow_tab[pos].hits       = it.hits;
                        shadow_tab[pos].watched    = it.watched;
                        shadow_tab[pos].muted      = it.muted;
                        r.status = STS_INSERTED;
                    end
                end
            end
            OP_FIND: begin
                pos      = key_lookup(it.key);
                r.status = (pos >= 0) ? STS_OK : STS_NOT_FOUND;
            end
            OP_READ: begin
                if (int'(it.index) < int'(shadow_used)) begin
                    r.status = STS_OK;
                    pos      = int'(it.index);
                end else begin
                    r.status = STS_RANGE;
                end
            end
            OP_CLEAR: begin
                shadow_clear();
                r.status = STS_OK;
            end
            default: r.status = STS_RANGE;
        endcase
        if (pos >= 0) begin
            r.slot  = SLOT_W'(pos);
            r.entry = shadow_tab[pos];
        end
        r.count = COUNT_W'(shadow_used);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // item planning
    // ------------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] stamp();
        case ($urandom_range(0, 3))
            0, 1: begin
                gen_clock = gen_clock + TIME_W'($urandom_range(1, 5000));
                return gen_clock;
            end
            2:       return TIME_W'({$urandom, $urandom});
            default: return TIME_W'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return KEY_W'($urandom);
    endfunction

    // every field random, caller overrides what matters
    function automatic t_item make_item(input logic [OP_W-1:0] op,
                                        input logic [KEY_W-1:0] key);
        t_item it;
        it.op         = op;
        it.key        = key;
        it.time_ms    = stamp();
        it.first_seen = TIME_W'({$urandom, $urandom});
        it.hits       = HITS_W'($urandom);
        it.watched    = 1'($urandom_range(0, 1));
        it.muted      = 1'($urandom_range(0, 1));
        it.index      = SLOT_W'($urandom_range(0, ENTRIES - 1));
        return it;
    endfunction

    function automatic void queue_item(input t_item it);
        planned_items.push_back(it);
        if (it.op == OP_HIT || it.op == OP_RESTORE) known_keys.push_back(it.key);
        if (it.op == OP_CLEAR) known_keys.delete();
    endfunction

    function automatic void plan(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [TIME_W-1:0] tm, input logic [TIME_W-1:0] first,
                                 input logic [HITS_W-1:0] hits, input logic w, input logic m,
                                 input logic [SLOT_W-1:0] idx);
        t_item it;
        it = '{op: op, key: key, time_ms: tm, first_seen: first, hits: hits,
               watched: w, muted: m, index: idx};
        queue_item(it);
    endfunction

    // fill an empty table with fresh keys, times drawn from a narrow window
    function automatic void fill_table(input int spread, input int pin_odds, input bit pin_all);
        t_item it;
        for (int i = 0; i < ENTRIES; i++) begin
            it = make_item((pin_all || $urandom_range(0, 3) == 0) ? OP_RESTORE : OP_HIT,
                           KEY_W'($urandom));
            it.time_ms = TIME_W'($urandom_range(0, spread));
            it.watched = pin_all ? 1'b1 : 1'($urandom_range(0, pin_odds) == 0);
            queue_item(it);
        end
    endfunction

    function automatic void mixed_traffic(input int n);
        t_item             it;
        logic [OP_W-1:0]   op;
        int                r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if      (r < 40) op = OP_HIT;
            else if (r < 52) op = OP_RESTORE;
            else if (r < 62) op = OP_SET_WATCHED;
            else if (r < 72) op = OP_SET_MUTED;
            else if (r < 82) op = OP_FIND;
            else if (r < 94) op = OP_READ;
            else if (r < 97) op = OP_CLEAR;
            else             op = OP_UNUSED;
            it = make_item(op, pick_key());
            // mostly read inside the used part of the table
            if (op == OP_READ && known_keys.size() != 0 && $urandom_range(0, 3) != 0)
                it.index = SLOT_W'($urandom_range(0, known_keys.size() - 1));
            queue_item(it);
        end
    endfunction

    // gap lengths: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    // ------------------------------------------------------------------------
    // driver: one item in flight on the input channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_idle  <= 0;
            send_calm  <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_idle != 0) begin
                i_in_valid <= 1'b0;
                send_idle  <= send_idle - 1;
            end else if (planned_items.size() != 0) begin
                nxt = planned_items.pop_front();
                i_in_valid      <= 1'b1;
                i_opcode        <= nxt.op;
                i_capcode       <= nxt.key;
                i_time_ms       <= nxt.time_ms;
                i_first_seen_ms <= nxt.first_seen;
                i_hit_count_in  <= nxt.hits;
                i_watched_in    <= nxt.watched;
                i_muted_in      <= nxt.muted;
                i_entry_index   <= nxt.index;
                // occasional back-to-back stretch with no gaps at all
                send_idle <= (send_calm != 0) ? 0 : idle_len();
                send_calm <= (send_calm != 0) ? send_calm - 1 :
                             (($urandom_range(0, 29) == 0) ? 40 : 0);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stalls after results and at random in between
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall  <= 0;
            recv_calm   <= 0;
        end else if (recv_stall != 0) begin
            i_out_ready <= 1'b0;
            recv_stall  <= recv_stall - 1;
        end else if (recv_calm != 0) begin
            i_out_ready <= 1'b1;
            recv_calm   <= recv_calm - 1;
        end else if (o_out_valid && i_out_ready) begin
            recv_stall  <= idle_len();
            i_out_ready <= 1'b0;
            // long ready-only stretch now and then
            recv_calm   <= ($urandom_range(0, 19) == 0) ? 2000 : 0;
        end else if ($urandom_range(0, 15) == 0) begin
            i_out_ready <= 1'b0;
            recv_stall  <= $urandom_range(0, 3);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on accept, compare on result
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // the expectation goes in before any result of the same edge is checked
            if (i_in_valid && o_in_ready) begin
                seen = '{op: i_opcode, key: i_capcode, time_ms: i_time_ms,
                         first_seen: i_first_seen_ms, hits: i_hit_count_in,
                         watched: i_watched_in, muted: i_muted_in, index: i_entry_index};
                awaited_results.push_back(table_apply(seen));
            end
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no item outstanding: status %0d", o_status);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status",            want.status,           o_status);
                    check_field("slot",              want.slot,             o_slot);
                    check_field("out_capcode",       want.entry.key,        o_out_capcode);
                    check_field("out_first_seen_ms", want.entry.first_seen,
                                o_out_first_seen_ms);
                    check_field("out_last_seen_ms",  want.entry.last_seen,
                                o_out_last_seen_ms);
                    check_field("out_hit_count",     want.entry.hits,       o_out_hit_count);
                    check_field("out_watched",       want.entry.watched,    o_out_watched);
                    check_field("out_muted",         want.entry.muted,      o_out_muted);
                    check_field("entry_count",       want.count,            o_entry_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_item it;
        int    k;
        shadow_clear();

        // directed: empty table corner cases
        plan(OP_FIND,        32'h0,        '0, '0, '0, 1'b0, 1'b0, 6'd0);
        plan(OP_READ,        32'h0,        '0, '0, '0, 1'b0, 1'b0, 6'd0);
        plan(OP_READ,        32'hFFFFFFFF, '1, '1, '1, 1'b1, 1'b1, 6'd63);
        plan(OP_UNUSED,      32'hFFFFFFFF, '1, '1, '1, 1'b1, 1'b1, 6'd63);
        plan(OP_CLEAR,       32'h0,        '0, '0, '0, 1'b0, 1'b0, 6'd0);
        plan(OP_SET_WATCHED, 32'h0,        '0, '0, '0, 1'b1, 1'b0, 6'd0);
        // directed: new entries from hits, then a repeat hit
        plan(OP_HIT,         32'h0,        '0, '1, '1, 1'b1, 1'b1, 6'd63);
        plan(OP_HIT,         32'hFFFFFFFF, '1, '0, '0, 1'b0, 1'b0, 6'd0);
        plan(OP_HIT,         32'h0,        '1, '0, '0, 1'b0, 1'b0, 6'd0);
        // directed: restore near saturation, then hit past it
        plan(OP_RESTORE,     32'h12345678, '1, '0, 32'hFFFFFFFE, 1'b1, 1'b1, 6'd0);
        plan(OP_HIT,         32'h12345678, 48'h1, '0, '0, 1'b0, 1'b0, 6'd0);
        plan(OP_HIT,         32'h12345678, 48'h2, '0, '0, 1'b0, 1'b0, 6'd0);
        // directed: duplicate restore reports the existing entry
        plan(OP_RESTORE,     32'h0,        48'h5, 48'h5, 32'h5, 1'b1, 1'b1, 6'd0);
        // directed: flag updates both ways and on an absent key, then find, reads and clear
        plan(OP_SET_WATCHED, 32'hFFFFFFFF, '0, '0, '0, 1'b1, 1'b0, 6'd0);
        plan(OP_SET_MUTED,   32'hFFFFFFFF, '0, '0, '0, 1'b0, 1'b1, 6'd0);
        plan(OP_SET_WATCHED, 32'hFFFFFFFF, '1, '1, '1, 1'b0, 1'b1, 6'd63);
        plan(OP_SET_MUTED,   32'hFFFFFFFF, '1, '1, '1, 1'b1, 1'b0, 6'd63);
        plan(OP_SET_MUTED,   32'hDEADBEEF, '0, '0, '0, 1'b0, 1'b1, 6'd0);
        plan(OP_FIND,        32'h12345678, '0, '0, '0, 1'b0, 1'b0, 6'd0);
        plan(OP_READ,        32'h0,        '0, '0, '0, 1'b0, 1'b0, 6'd2);
        plan(OP_READ,        32'h0,        '0, '0, '0, 1'b0, 1'b0, 6'd3);
        plan(OP_CLEAR,       32'hFFFFFFFF, '1, '1, '1, 1'b1, 1'b1, 6'd63);
        plan(OP_READ,        32'h0,        '0, '0, '0, 1'b0, 1'b0, 6'd0);

        // every entry pinned: new-key hits are refused until one is released; restores are refused as the table is full
        queue_item(make_item(OP_CLEAR, pick_key()));
        fill_table(1000, 0, 1'b1);
        queue_item(make_item(OP_HIT, KEY_W'($urandom)));
        queue_item(make_item(OP_RESTORE, KEY_W'($urandom)));
        queue_item(make_item(OP_RESTORE, known_keys[$urandom_range(0, ENTRIES - 1)]));
        queue_item(make_item(OP_HIT, known_keys[$urandom_range(0, ENTRIES - 1)]));
        k  = $urandom_range(0, ENTRIES - 1);
        it = make_item(OP_SET_WATCHED, known_keys[k]);
        it.watched = 1'b0;
        queue_item(it);
        queue_item(make_item(OP_HIT, KEY_W'($urandom)));
        it = make_item(OP_READ, '0);
        it.index = SLOT_W'(k);
        queue_item(it);
        queue_item(make_item(OP_HIT, KEY_W'($urandom)));

        // full table with tied times: lru replacement with a few pinned entries
        queue_item(make_item(OP_CLEAR, pick_key()));
        fill_table(3, 5, 1'b0);
        for (int i = 0; i < 24; i++) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    it = make_item(OP_HIT, KEY_W'($urandom));
                    it.time_ms = TIME_W'($urandom_range(0, 4));
                end
                2:       it = make_item(OP_HIT, pick_key());
                3:       it = make_item(OP_READ, pick_key());
                4:       it = make_item(OP_SET_WATCHED, pick_key());
                default: it = make_item(OP_RESTORE, pick_key());
            endcase
            queue_item(it);
        end

        // free-running mixed traffic for the rest
        while (planned_items.size() < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 1) == 0) queue_item(make_item(OP_CLEAR, pick_key()));
            mixed_traffic($urandom_range(20, 60));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (planned_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        // let any late or spurious result show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/plt_pkg.sv
rtl/plt_mem.sv
rtl/plt_ctrl.sv
rtl/pinned_lru_identity_table.sv
tb/sv/tb_pinned_lru_identity_table.sv
